// ===== rtl/brm_pkg.sv =====
`default_nettype none
package brm_pkg;

  localparam int LIT_W  = 9;
  localparam int MODE_W = 2;
  localparam int STAT_W = 2;

  localparam int CLAUSE_CAPACITY_DEF = 16;
  localparam int VARIABLE_LIMIT      = 255;

  localparam logic [MODE_W-1:0] MODE_LOAD_FIRST  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LOAD_SECOND = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RESOLVE     = 2'd2;

  localparam logic [STAT_W-1:0] ST_LITERAL    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY      = 2'd1;
  localparam logic [STAT_W-1:0] ST_NO_PAIR    = 2'd2;
  localparam logic [STAT_W-1:0] ST_MANY_PAIRS = 2'd3;

  typedef struct packed {
    logic              load_first;
    logic              load_second;
    logic              clear;
    logic              scan_start;
    logic              scan_step;
    logic              merge_start;
    logic              adv_i;
    logic              adv_j;
    logic              take_pick;
    logic              push;
    logic              push_held;
    logic              push_last;
    logic [STAT_W-1:0] push_status;
  } dp_cmd_t;

  typedef struct packed {
    logic lit_ok;
    logic scan_done;
    logic pairs_zero;
    logic pairs_many;
    logic i_done;
    logic j_done;
    logic f_skip;
    logic s_skip;
    logic pick_first;
    logic dup;
    logic held_v;
    logic out_free;
  } dp_stat_t;

  function automatic logic [LIT_W-1:0] lit_mag(input logic signed [LIT_W-1:0] x);
    logic signed [LIT_W-1:0] n;
    n = -x;
    return x[LIT_W-1] ? LIT_W'(n) : LIT_W'(x);
  endfunction

endpackage
`default_nettype wire

// ===== rtl/binary_resolution_merge.sv =====
`default_nettype none
// Binary resolvent of two sorted clauses of signed 9-bit literals. A load
// transfer (mode 0 or 1) inserts one literal into its clause store; zero,
// out-of-range, duplicate and overflow literals are dropped. A resolve
// transfer (mode 2) first counts complementary pairs (one first-store
// literal against the whole second store per cycle), then one shared merge
// pointer pair consumes one stored literal per cycle unless the result side
// stalls. Results leave through a one-entry output register; the last one
// carries out_last. Both stores are empty after a resolve. A new transfer is
// taken only once the previous one is done.
module binary_resolution_merge import brm_pkg::*; #(
  parameter int CLAUSE_CAPACITY = CLAUSE_CAPACITY_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [MODE_W-1:0]       in_mode,
  input  wire logic signed [LIT_W-1:0] in_literal,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic signed [LIT_W-1:0]      out_literal,
  output logic [STAT_W-1:0]            out_status,
  output logic                         out_last
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  brm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_mode  (in_mode),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  brm_datapath #(.CAP(CLAUSE_CAPACITY)) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .in_literal  (in_literal),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .out_literal (out_literal),
    .out_status  (out_status),
    .out_last    (out_last)
  );

endmodule
`default_nettype wire

// ===== rtl/brm_store.sv =====
`default_nettype none
module brm_store import brm_pkg::*; #(
  parameter int CAP   = CLAUSE_CAPACITY_DEF,
  parameter int CNT_W = $clog2(CAP + 1),
  parameter int IDX_W = (CAP > 1) ? $clog2(CAP) : 1
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    load,
  input  wire logic                    clear,
  input  wire logic signed [LIT_W-1:0] lit,
  input  wire logic [IDX_W-1:0]        rd_idx,
  output logic [CNT_W-1:0]             count,
  output logic signed [LIT_W-1:0]      rd_data,
  output logic signed [LIT_W-1:0]      entries [CAP]
);

  logic signed [LIT_W-1:0] entries_r   [CAP];
  logic signed [LIT_W-1:0] entries_nxt [CAP];
  logic [CNT_W-1:0]        count_r;
  logic [CAP-1:0]          lt;
  logic [CAP-1:0]          hit;
  logic                    full;
  logic                    do_ins;

  always_comb begin
    for (int k = 0; k < CAP; k++) begin
      lt[k]  = (CNT_W'(k) < count_r) && (entries_r[k] < lit);
      hit[k] = (CNT_W'(k) < count_r) && (entries_r[k] == lit);
    end
    full   = (count_r == CNT_W'(CAP));
    do_ins = load && !(|hit) && !full;
    // sorted insert: keep lower entries, place literal, shift the rest up
    entries_nxt[0] = lt[0] ? entries_r[0] : lit;
    for (int k = 1; k < CAP; k++) begin
      if (lt[k]) begin
        entries_nxt[k] = entries_r[k];
      end else if (lt[k-1]) begin
        entries_nxt[k] = lit;
      end else begin
        entries_nxt[k] = entries_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_ins) begin
      entries_r <= entries_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (clear) begin
      count_r <= '0;
    end else if (do_ins) begin
      count_r <= count_r + 1'b1;
    end
  end

  assign count   = count_r;
  assign rd_data = entries_r[rd_idx];
  assign entries = entries_r;

endmodule
`default_nettype wire

// ===== rtl/brm_datapath.sv =====
`default_nettype none
module brm_datapath import brm_pkg::*; #(
  parameter int CAP = CLAUSE_CAPACITY_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire dp_cmd_t                 cmd,
  output dp_stat_t                     stat,
  input  wire logic signed [LIT_W-1:0] in_literal,
  input  wire logic                    out_ready,
  output logic                         out_valid,
  output logic signed [LIT_W-1:0]      out_literal,
  output logic [STAT_W-1:0]            out_status,
  output logic                         out_last
);

  localparam int CNT_W = $clog2(CAP + 1);
  localparam int IDX_W = (CAP > 1) ? $clog2(CAP) : 1;

  logic [CNT_W-1:0]          n1;
  logic [CNT_W-1:0]          n2;
  logic signed [LIT_W-1:0]   f_cur;
  logic signed [LIT_W-1:0]   s_cur;
  logic signed [LIT_W-1:0]   f_entries [CAP];
  logic signed [LIT_W-1:0]   s_entries [CAP];

  logic [CNT_W-1:0]          i_r;
  logic [CNT_W-1:0]          j_r;
  logic [LIT_W-1:0]          var_r;
  logic [1:0]                pairs_r;
  logic signed [LIT_W-1:0]   held_r;
  logic                      held_v_r;
  logic                      out_valid_r;
  logic signed [LIT_W-1:0]   out_literal_r;
  logic [STAT_W-1:0]         out_status_r;
  logic                      out_last_r;

  logic signed [LIT_W:0]     f_neg;
  logic [CAP-1:0]            mask;
  logic                      multi;
  logic signed [LIT_W-1:0]   pick;
  logic                      i_done;
  logic                      j_done;
  logic                      pick_first;

  brm_store #(.CAP(CAP)) u_first (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (cmd.load_first),
    .clear   (cmd.clear),
    .lit     (in_literal),
    .rd_idx  (i_r[IDX_W-1:0]),
    .count   (n1),
    .rd_data (f_cur),
    .entries (f_entries)
  );

  brm_store #(.CAP(CAP)) u_second (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (cmd.load_second),
    .clear   (cmd.clear),
    .lit     (in_literal),
    .rd_idx  (j_r[IDX_W-1:0]),
    .count   (n2),
    .rd_data (s_cur),
    .entries (s_entries)
  );

  always_comb begin
    // widened so that the most negative code does not alias on negation
    f_neg = -{f_cur[LIT_W-1], f_cur};
    for (int k = 0; k < CAP; k++) begin
      mask[k] = (CNT_W'(k) < n2) && ({s_entries[k][LIT_W-1], s_entries[k]} == f_neg);
    end
    multi      = (mask & (mask - 1'b1)) != '0;
    i_done     = (i_r >= n1);
    j_done     = (j_r >= n2);
    pick_first = j_done || (!i_done && (f_cur <= s_cur));
    pick       = pick_first ? f_cur : s_cur;
  end

  always_comb begin
    stat.lit_ok     = (in_literal != '0) &&
                      (32'(lit_mag(in_literal)) <= 32'(VARIABLE_LIMIT));
    stat.scan_done  = i_done;
    stat.pairs_zero = (pairs_r == 2'd0);
    stat.pairs_many = pairs_r[1];
    stat.i_done     = i_done;
    stat.j_done     = j_done;
    stat.f_skip     = (lit_mag(f_cur) == var_r);
    stat.s_skip     = (lit_mag(s_cur) == var_r);
    stat.pick_first = pick_first;
    stat.dup        = held_v_r && (pick == held_r);
    stat.held_v     = held_v_r;
    stat.out_free   = !out_valid_r || out_ready;
  end

  // walk pointers and pair count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_r      <= '0;
      j_r      <= '0;
      pairs_r  <= 2'd0;
      held_v_r <= 1'b0;
    end else begin
      if (cmd.scan_start || cmd.merge_start) begin
        i_r <= '0;
      end else if (cmd.scan_step || cmd.adv_i) begin
        i_r <= i_r + 1'b1;
      end
      if (cmd.merge_start) begin
        j_r <= '0;
      end else if (cmd.adv_j) begin
        j_r <= j_r + 1'b1;
      end
      if (cmd.scan_start) begin
        pairs_r <= 2'd0;
      end else if (cmd.scan_step && (mask != '0)) begin
        pairs_r <= ((pairs_r != 2'd0) || multi) ? 2'd2 : 2'd1;
      end
      if (cmd.merge_start) begin
        held_v_r <= 1'b0;
      end else if (cmd.take_pick) begin
        held_v_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_step && (mask != '0)) begin
      var_r <= lit_mag(f_cur);
    end
    if (cmd.take_pick) begin
      held_r <= pick;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.push) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_literal_r <= cmd.push_held ? held_r : '0;
      out_status_r  <= cmd.push_status;
      out_last_r    <= cmd.push_last;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_literal = out_literal_r;
  assign out_status  = out_status_r;
  assign out_last    = out_last_r;

endmodule
`default_nettype wire

// ===== rtl/brm_ctrl.sv =====
`default_nettype none
module brm_ctrl import brm_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic [MODE_W-1:0] in_mode,
  output logic                   in_ready,
  input  wire dp_stat_t          stat,
  output dp_cmd_t                cmd
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_MERGE  = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic       accept;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_mode)
            MODE_LOAD_FIRST:  cmd.load_first  = stat.lit_ok;
            MODE_LOAD_SECOND: cmd.load_second = stat.lit_ok;
            MODE_RESOLVE: begin
              cmd.scan_start = 1'b1;
              state_nxt      = S_SCAN;
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        if (!stat.scan_done) begin
          cmd.scan_step = 1'b1;
        end else if (!stat.pairs_zero && !stat.pairs_many) begin
          cmd.merge_start = 1'b1;
          state_nxt       = S_MERGE;
        end else if (stat.out_free) begin
          cmd.push        = 1'b1;
          cmd.push_last   = 1'b1;
          cmd.push_status = stat.pairs_zero ? ST_NO_PAIR : ST_MANY_PAIRS;
          cmd.clear       = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      S_MERGE: begin
        if (!stat.i_done && stat.f_skip) begin
          cmd.adv_i = 1'b1;
        end else if (!stat.j_done && stat.s_skip) begin
          cmd.adv_j = 1'b1;
        end else if (stat.i_done && stat.j_done) begin
          state_nxt = S_FINISH;
        end else if (stat.dup) begin
          cmd.adv_i = stat.pick_first;
          cmd.adv_j = !stat.pick_first;
        end else if (!stat.held_v || stat.out_free) begin
          // held literal is not the last one, send it on
          cmd.push        = stat.held_v;
          cmd.push_held   = 1'b1;
          cmd.push_status = ST_LITERAL;
          cmd.take_pick   = 1'b1;
          cmd.adv_i       = stat.pick_first;
          cmd.adv_j       = !stat.pick_first;
        end
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.push        = 1'b1;
          cmd.push_held   = stat.held_v;
          cmd.push_last   = 1'b1;
          cmd.push_status = stat.held_v ? ST_LITERAL : ST_EMPTY;
          cmd.clear       = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
module testbench;
  import brm_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int ITEM_TARGET   = 400;
  localparam int QUIET_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 60;
  localparam int LONG_STALL    = 300;
  localparam int N_DIRECTED    = 23;

  typedef struct {
    logic signed [LIT_W-1:0] lit;
    logic [STAT_W-1:0]       status;
    logic                    last;
  } resolvent_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [LIT_W-1:0]  lit;
    logic              known;
    logic [STAT_W-1:0] status;
  } stim_row_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [MODE_W-1:0]       in_mode = MODE_LOAD_FIRST;
  logic signed [LIT_W-1:0] in_literal = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic signed [LIT_W-1:0] out_literal;
  logic [STAT_W-1:0]       out_status;
  logic                    out_last;

  logic idle_en = 1'b1;
  logic stall_req = 1'b0;
  logic stall_done = 1'b0;

  logic signed [LIT_W-1:0] clause [2][CLAUSE_CAPACITY_DEF];
  int                      fill [2] = '{0, 0};
  resolvent_t              pending_resolvents [$];
  stim_row_t               directed [N_DIRECTED];
  int                      mismatches = 0;
  int                      items_sent = 0;
  int                      quiet_cycles = 0;

  binary_resolution_merge i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_mode     (in_mode),
    .in_literal  (in_literal),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_literal (out_literal),
    .out_status  (out_status),
    .out_last    (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int var_of(input logic signed [LIT_W-1:0] x);
    int v;
    v = x;
    return (v < 0) ? -v : v;
  endfunction

  function automatic logic signed [LIT_W-1:0] pick_literal(input int span);
    int v;
    v = $urandom_range(1, span);
    if ($urandom_range(0, 1) == 1) v = -v;
    return LIT_W'(v);
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("mismatch: %s", msg);
    mismatches++;
  endtask

  task automatic expect_result(input logic signed [LIT_W-1:0] lit,
                               input logic [STAT_W-1:0] status, input logic last);
    resolvent_t r;
    r.lit = lit;
    r.status = status;
    r.last = last;
    pending_resolvents.push_back(r);
  endtask

  // sorted insert, drops bad, duplicate and overflow literals
  task automatic store_literal(input int side, input logic signed [LIT_W-1:0] lit);
    int pos;
    int k;
    if (lit == 0 || var_of(lit) > VARIABLE_LIMIT) return;
    pos = 0;
    while (pos < fill[side] && clause[side][pos] < lit) pos++;
    if (pos < fill[side] && clause[side][pos] == lit) return;
    if (fill[side] >= CLAUSE_CAPACITY_DEF) return;
    for (k = fill[side]; k > pos; k--) clause[side][k] = clause[side][k-1];
    clause[side][pos] = lit;
    fill[side]++;
  endtask

  task automatic predict_resolvent(input bit keep);
    int                      pairs;
    int                      pivot;
    int                      i;
    int                      j;
    int                      emitted;
    bit                      have_prev;
    logic signed [LIT_W-1:0] pick;
    logic signed [LIT_W-1:0] prev;
    pairs = 0;
    pivot = 0;
    for (i = 0; i < fill[0]; i++)
      for (j = 0; j < fill[1]; j++)
        if (clause[0][i] == -clause[1][j]) begin
          pairs++;
          pivot = var_of(clause[0][i]);
        end
    if (keep) begin
      if (pairs == 0) begin
        expect_result('0, ST_NO_PAIR, 1'b1);
      end else if (pairs > 1) begin
        expect_result('0, ST_MANY_PAIRS, 1'b1);
      end else begin
        i = 0;
        j = 0;
        emitted = 0;
        have_prev = 1'b0;
        prev = '0;
        while (1) begin
          while (i < fill[0] && var_of(clause[0][i]) == pivot) i++;
          while (j < fill[1] && var_of(clause[1][j]) == pivot) j++;
          if (i >= fill[0] && j >= fill[1]) break;
          if (j >= fill[1] || (i < fill[0] && clause[0][i] <= clause[1][j])) begin
            pick = clause[0][i];
            i++;
          end else begin
            pick = clause[1][j];
            j++;
          end
          if (!(have_prev && pick == prev)) begin
            expect_result(pick, ST_LITERAL, 1'b0);
            emitted++;
            prev = pick;
            have_prev = 1'b1;
          end
        end
        if (emitted == 0) expect_result('0, ST_EMPTY, 1'b1);
        else pending_resolvents[pending_resolvents.size()-1].last = 1'b1;
      end
    end
    fill[0] = 0;
    fill[1] = 0;
  endtask

  // drive one item, wait for its transfer, then update the prediction
  task automatic offer(input logic [MODE_W-1:0] mode, input logic signed [LIT_W-1:0] lit,
                       input logic known, input logic [STAT_W-1:0] status);
    while (idle_en && $urandom_range(0, 99) < 13) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= mode;
    in_literal <= lit;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    case (mode)
      MODE_LOAD_FIRST:  store_literal(0, lit);
      MODE_LOAD_SECOND: store_literal(1, lit);
      MODE_RESOLVE:     predict_resolvent(!known);
      default: ;
    endcase
    if (known) expect_result('0, status, 1'b1);
    if (mode != MODE_UNUSED) items_sent++;
  endtask

  task automatic load_noise();
    logic [MODE_W-1:0] side;
    side = ($urandom_range(0, 1) == 1) ? MODE_LOAD_SECOND : MODE_LOAD_FIRST;
    case ($urandom_range(0, 3))
      0: offer(side, '0, 1'b0, ST_LITERAL);
      1: offer(side, 9'h100, 1'b0, ST_LITERAL);
      2: offer(side, LIT_W'($urandom), 1'b0, ST_LITERAL);
      default: offer(MODE_UNUSED, LIT_W'($urandom), 1'b0, ST_LITERAL);
    endcase
  endtask

  // load both clauses, mostly around one complementary pivot, then usually resolve
  task automatic clause_pair_round();
    int                      span;
    int                      n_a;
    int                      n_b;
    logic signed [LIT_W-1:0] lit;
    span = ($urandom_range(0, 3) == 0) ? VARIABLE_LIMIT : $urandom_range(3, 12);
    n_a = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 20) : $urandom_range(0, 6);
    n_b = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 20) : $urandom_range(0, 6);
    if ($urandom_range(0, 9) < 7) begin
      lit = pick_literal(span);
      offer(MODE_LOAD_FIRST, lit, 1'b0, ST_LITERAL);
      offer(MODE_LOAD_SECOND, -lit, 1'b0, ST_LITERAL);
    end
    while (n_a + n_b > 0) begin
      if ($urandom_range(0, 19) == 0) begin
        load_noise();
      end else if (n_b == 0 || (n_a > 0 && $urandom_range(0, 1) == 1)) begin
        offer(MODE_LOAD_FIRST, pick_literal(span), 1'b0, ST_LITERAL);
        n_a--;
      end else begin
        offer(MODE_LOAD_SECOND, pick_literal(span), 1'b0, ST_LITERAL);
        n_b--;
      end
    end
    if ($urandom_range(0, 14) != 0) offer(MODE_RESOLVE, LIT_W'($urandom), 1'b0, ST_LITERAL);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending_resolvents.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (stall_req && !stall_done) begin
        out_ready <= 1'b0;
        repeat (LONG_STALL) @(posedge clk);
        stall_done <= 1'b1;
      end else begin
        out_ready <= !(idle_en && $urandom_range(0, 99) < 13);
      end
    end
  end

  always @(posedge clk) begin : check_transfer
    resolvent_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_resolvents.size() == 0) begin
        flag_mismatch($sformatf("unexpected transfer lit %0d status %0d last %0d",
                                out_literal, out_status, out_last));
      end else begin
        want = pending_resolvents.pop_front();
        if (out_literal !== want.lit || out_status !== want.status ||
            out_last !== want.last)
          flag_mismatch($sformatf(
            "got lit %0d status %0d last %0d, want lit %0d status %0d last %0d",
            out_literal, out_status, out_last,
            want.lit, want.status, want.last));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int r;
    directed = '{
      '{MODE_RESOLVE,     9'h000,   1'b1, ST_NO_PAIR},
      '{MODE_LOAD_FIRST,  9'sd5,    1'b0, ST_LITERAL},
      '{MODE_LOAD_SECOND, -9'sd5,   1'b0, ST_LITERAL},
      '{MODE_RESOLVE,     9'h1ff,   1'b1, ST_EMPTY},
      '{MODE_LOAD_FIRST,  9'sd255,  1'b0, ST_LITERAL},
      '{MODE_LOAD_FIRST,  -9'sd255, 1'b0, ST_LITERAL},
      '{MODE_LOAD_FIRST,  9'h000,   1'b0, ST_LITERAL},
      '{MODE_LOAD_FIRST,  9'h100,   1'b0, ST_LITERAL},
      '{MODE_LOAD_FIRST,  9'sd255,  1'b0, ST_LITERAL},
      '{MODE_UNUSED,      9'sd7,    1'b0, ST_LITERAL},
      '{MODE_LOAD_SECOND, -9'sd255, 1'b0, ST_LITERAL},
      '{MODE_LOAD_SECOND, 9'sd1,    1'b0, ST_LITERAL},
      '{MODE_LOAD_SECOND, -9'sd254, 1'b0, ST_LITERAL},
      '{MODE_RESOLVE,     -9'sd1,   1'b0, ST_LITERAL},
      '{MODE_LOAD_FIRST,  9'sd3,    1'b0, ST_LITERAL},
      '{MODE_LOAD_FIRST,  -9'sd3,   1'b0, ST_LITERAL},
      '{MODE_LOAD_SECOND, -9'sd3,   1'b0, ST_LITERAL},
      '{MODE_RESOLVE,     9'h0ff,   1'b1, ST_EMPTY},
      '{MODE_LOAD_FIRST,  9'sd2,    1'b0, ST_LITERAL},
      '{MODE_LOAD_FIRST,  9'sd9,    1'b0, ST_LITERAL},
      '{MODE_LOAD_SECOND, -9'sd2,   1'b0, ST_LITERAL},
      '{MODE_LOAD_SECOND, -9'sd9,   1'b0, ST_LITERAL},
      '{MODE_RESOLVE,     9'h100,   1'b1, ST_MANY_PAIRS}
    };
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (r = 0; r < N_DIRECTED; r++)
      offer(directed[r].mode, directed[r].lit, directed[r].known, directed[r].status);
    while (items_sent < 130) clause_pair_round();
    // receiver holds off while loads and resolves keep coming
    stall_req <= 1'b1;
    while (items_sent < 180) clause_pair_round();
    settle();
    idle_en <= 1'b0;
    while (items_sent < 290) clause_pair_round();
    idle_en <= 1'b1;
    while (items_sent < ITEM_TARGET) clause_pair_round();
    settle();
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
